>>> rtl/mfcp_pkg.sv
// Shared types and constants of the masked frame cross product block.
// No dependencies; mfcp_cell and masked_frame_cross_product import this package.
package mfcp_pkg;

	localparam int MAX_FRAMES_DEF = 8;
	localparam int MAX_PIXELS_DEF = 1024;
	localparam int SAMPLE_W       = 16;
	localparam int WEIGHT_W       = 17;
	localparam int SUM_W          = 48;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 11;

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_LOAD_M  = 2'd2,
		ACT_COMPUTE = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MASK_ENABLE = 2'd0,
		CFG_PIXEL_COUNT = 2'd1,
		CFG_FRAMES_A    = 2'd2,
		CFG_FRAMES_B    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// One pixel token walking down the cell chain.
	typedef struct packed {
		logic                       valid;
		logic                       first;
		logic                       last;
		logic signed [SAMPLE_W-1:0] va;
		logic [WEIGHT_W-1:0]        w;
	} tok_t;

endpackage

>>> rtl/mfcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfcp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mfcp_cell.sv
// One chain cell: owns one cube B frame, accumulates one weighted inner product.
// Depends on mfcp_pkg and mfcp_ram.
module mfcp_cell import mfcp_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int PW         = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tok_t                    tok_i,
	input  logic [PW-1:0]           p_i,
	output tok_t                    tok_o,
	output logic [PW-1:0]           p_o,
	input  logic                    wr_en_i,
	input  logic [PW-1:0]           wr_addr_i,
	input  logic [SAMPLE_W-1:0]     wr_data_i,
	input  logic                    shift_i,
	input  logic signed [SUM_W-1:0] res_i,
	output logic signed [SUM_W-1:0] res_o,
	output logic                    cap_o
);

	tok_t                           tok_s1;
	logic [PW-1:0]                  p_s1;
	logic [SAMPLE_W-1:0]            vb_raw;
	logic                           v_s2, first_s2, last_s2;
	logic signed [2*SAMPLE_W-1:0]   prod1_s2;
	logic [WEIGHT_W-1:0]            w_s2;
	logic                           v_s3, first_s3, last_s3;
	logic signed [SUM_W-1:0]        prod2_s3;
	logic signed [49:0]             prod2_full;
	logic signed [SUM_W-1:0]        term, base, acc_q, res_q, sat;
	logic signed [SUM_W:0]          sum;
	logic                           cap_q;

	mfcp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PIXELS), .AW(PW)) u_bank (
		.clk   (clk),
		.we    (wr_en_i),
		.waddr (wr_addr_i),
		.wdata (wr_data_i),
		.raddr (p_i),
		.rdata (vb_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			cap_q  <= 1'b0;
		end else begin
			tok_s1 <= tok_i;
			v_s2   <= tok_s1.valid;
			v_s3   <= v_s2;
			cap_q  <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1         <= p_i;
		first_s2     <= tok_s1.first;
		last_s2      <= tok_s1.last;
		prod1_s2     <= tok_s1.va * $signed(vb_raw);
		w_s2         <= tok_s1.w;
		first_s3     <= first_s2;
		last_s3      <= last_s2;
		prod2_s3     <= prod2_full[SUM_W-1:0];
	end

	always_comb begin
		// zero weight gives a zero term whatever the samples hold
		if (w_s2 == '0) begin
			prod2_full = '0;
		end else begin
			prod2_full = prod1_s2 * $signed({1'b0, w_s2});
		end
		term       = prod2_s3 >>> 15;
		base       = first_s3 ? '0 : acc_q;
		sum        = {base[SUM_W-1], base} + {term[SUM_W-1], term};
		if (sum[SUM_W] != sum[SUM_W-1]) begin
			sat = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat = sum[SUM_W-1:0];
		end
	end

	// Accumulate, capture on the final pixel, shift results toward cell zero.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= sat;
		end
		if (v_s3 && last_s3) begin
			res_q <= sat;
		end else if (shift_i) begin
			res_q <= res_i;
		end
	end

	assign tok_o = tok_s1;
	assign p_o   = p_s1;
	assign res_o = res_q;
	assign cap_o = cap_q;

endmodule

>>> rtl/masked_frame_cross_product.sv
// Masked frame cross product: weighted Gram matrix of two frame stacks.
// Depends on mfcp_pkg, mfcp_ram and mfcp_cell.
//
// Load items (cube A sample, cube B sample, mask value) each write one RAM entry
// and are accepted whenever no compute runs. A compute item produces
// frames_a*frames_b results, cube A frame outer, cube B frame inner. Each cube B
// frame lives in its own cell of a chain; one token per pixel, carrying the cube
// A sample and the squared-mask weight, walks down the chain one cell per cycle,
// so all cube B frames of one cube A row accumulate together. Each row sweeps
// its pixel_count pixels (at least one token), drains until the far cell has
// captured its sum, then shifts its frames_b results out, pausing while the
// result side stalls. The pixel sweep reads cube A through its single read port.
// Input items are held off with item_stall during a compute. Sums saturate to
// 48 bits after every term.
module masked_frame_cross_product import mfcp_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  action,
	input  logic [2:0]                  frame_index,
	input  logic [9:0]                  pixel_index,
	input  logic signed [SAMPLE_W-1:0]  sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [SUM_W-1:0]     product,
	output logic [2:0]                  row_a,
	output logic [2:0]                  col_b,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int PCW   = $clog2(MAX_PIXELS + 1);
	localparam int FCW   = $clog2(MAX_FRAMES + 1);
	localparam int DEPTH = MAX_FRAMES * MAX_PIXELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic        mask_enable_q;
	logic [10:0] pixel_count_q;
	logic [3:0]  frames_a_q, frames_b_q;

	state_t          state_q, state_d;
	logic [PCW-1:0]  p_q, np;
	logic [FCW-1:0]  a_q, e_q, na, nb;
	logic            accept, load_a, load_m, start;
	logic            issue, p_last, b_last, a_last, out_free, out_load;
	logic            load_ok;

	// Feeder pipeline: issue -> RAM read (s1) -> weight multiply (s2)
	logic                         v_s1, first_s1, last_s1, zero_s1;
	logic                         v_s2, first_s2, last_s2, zero_s2;
	logic [PW-1:0]                p_s1, p_s2;
	logic [SAMPLE_W-1:0]          a_rd, m_rd;
	logic signed [SAMPLE_W-1:0]   va_s2;
	logic signed [2*SAMPLE_W-1:0] mm_s2;
	tok_t                         feed_tok;

	// Cell chain wiring
	tok_t                    tok_chain [MAX_FRAMES];
	logic [PW-1:0]           p_chain   [MAX_FRAMES];
	logic signed [SUM_W-1:0] res_chain [MAX_FRAMES];
	logic                    cap_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enable_q <= 1'b0;
			pixel_count_q <= 11'd1024;
			frames_a_q    <= 4'd8;
			frames_b_q    <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				CFG_PIXEL_COUNT: pixel_count_q <= cfg_data;
				CFG_FRAMES_A:    frames_a_q    <= cfg_data[3:0];
				CFG_FRAMES_B:    frames_b_q    <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	// Clamp the counts to what the stores hold
	assign np = (32'(pixel_count_q) > MAX_PIXELS) ? PCW'(MAX_PIXELS) : PCW'(pixel_count_q);
	assign na = (32'(frames_a_q) > MAX_FRAMES) ? FCW'(MAX_FRAMES) : FCW'(frames_a_q);
	assign nb = (32'(frames_b_q) > MAX_FRAMES) ? FCW'(MAX_FRAMES) : FCW'(frames_b_q);

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign load_ok    = (32'(pixel_index) < MAX_PIXELS);
	assign load_a     = accept && (action_t'(action) == ACT_LOAD_A) && load_ok
	                    && (32'(frame_index) < MAX_FRAMES);
	assign load_m     = accept && (action_t'(action) == ACT_LOAD_M) && load_ok;
	assign start      = accept && (action_t'(action) == ACT_COMPUTE)
	                    && (na != '0) && (nb != '0);

	assign p_last   = (np == '0) || (p_q == np - PCW'(1));
	assign b_last   = (e_q == nb - FCW'(1));
	assign a_last   = (a_q == na - FCW'(1));
	assign out_free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				issue = 1'b1;
				if (p_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// hold until the far cell has captured its sum
				if (cap_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_load = out_free;
				if (out_free && b_last) begin
					state_d = a_last ? ST_IDLE : ST_SWEEP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Row, pixel and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			p_q <= '0;
			e_q <= '0;
		end else begin
			if (start) begin
				a_q <= '0;
				p_q <= '0;
				e_q <= '0;
			end
			if (issue) begin
				p_q <= p_q + PCW'(1);
			end
			if (out_load) begin
				if (b_last) begin
					e_q <= '0;
					a_q <= a_q + FCW'(1);
					p_q <= '0;
				end else begin
					e_q <= e_q + FCW'(1);
				end
			end
		end
	end

	mfcp_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH), .AW(AW)) u_cube_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (AW'(32'(frame_index) * 32'(MAX_PIXELS) + 32'(pixel_index))),
		.wdata (sample),
		.raddr (AW'(32'(a_q) * 32'(MAX_PIXELS) + 32'(p_q))),
		.rdata (a_rd)
	);

	mfcp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PIXELS), .AW(PW)) u_mask (
		.clk   (clk),
		.we    (load_m),
		.waddr (PW'(pixel_index)),
		.wdata (sample),
		.raddr (p_q[PW-1:0]),
		.rdata (m_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (p_q == '0);
		last_s1  <= p_last;
		zero_s1  <= (np == '0);
		p_s1     <= p_q[PW-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		zero_s2  <= zero_s1;
		p_s2     <= p_s1;
		va_s2    <= $signed(a_rd);
		mm_s2    <= $signed(m_rd) * $signed(m_rd);
	end

	// An empty pixel range sends one token of weight zero so the sums read zero
	always_comb begin
		feed_tok.valid = v_s2;
		feed_tok.first = first_s2;
		feed_tok.last  = last_s2;
		feed_tok.va    = va_s2;
		if (zero_s2) begin
			feed_tok.w = '0;
		end else if (mask_enable_q) begin
			feed_tok.w = mm_s2[2*SAMPLE_W-1:15];
		end else begin
			feed_tok.w = WEIGHT_W'(32768);
		end
	end

	assign tok_chain[0] = feed_tok;
	assign p_chain[0]   = p_s2;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		logic b_wr;
		assign b_wr = accept && (action_t'(action) == ACT_LOAD_B) && load_ok
		              && (32'(frame_index) == i);
		if (i < MAX_FRAMES - 1) begin : g_mid
			mfcp_cell #(.MAX_PIXELS(MAX_PIXELS), .PW(PW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.tok_i     (tok_chain[i]),
				.p_i       (p_chain[i]),
				.tok_o     (tok_chain[i+1]),
				.p_o       (p_chain[i+1]),
				.wr_en_i   (b_wr),
				.wr_addr_i (PW'(pixel_index)),
				.wr_data_i (sample),
				.shift_i   (out_load),
				.res_i     (res_chain[i+1]),
				.res_o     (res_chain[i]),
				.cap_o     ()
			);
		end else begin : g_end
			mfcp_cell #(.MAX_PIXELS(MAX_PIXELS), .PW(PW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.tok_i     (tok_chain[i]),
				.p_i       (p_chain[i]),
				.tok_o     (),
				.p_o       (),
				.wr_en_i   (b_wr),
				.wr_addr_i (PW'(pixel_index)),
				.wr_data_i (sample),
				.shift_i   (out_load),
				.res_i     ('0),
				.res_o     (res_chain[i]),
				.cap_o     (cap_last)
			);
		end
	end

	// Output register: take cell zero's sum and advance the result chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product <= res_chain[0];
			row_a   <= 3'(a_q);
			col_b   <= 3'(e_q);
			last    <= a_last && b_last;
		end
	end

`ifndef SYNTHESIS
	a_cap_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cap_last |-> (state_q == ST_DRAIN))
		else $error("far cell captured outside drain");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (e_q < nb))
		else $error("emit column beyond frames_b");
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SWEEP) && (np != '0)) |-> (p_q < np))
		else $error("pixel sweep beyond pixel_count");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (a_q < na))
		else $error("row counter beyond frames_a");
`endif

endmodule
